// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the clipper RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SHHPC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication violated");

// The consequent must hold in the cycle after the antecedent.
`define SHHPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication violated");

`endif

// ===== hw/rtl/shhpc_pkg.sv =====
// ----------------------------------------------------------------------------
// Half-plane clipper package
// Vertex type, register indexes, sequencer states and field helpers.
// ----------------------------------------------------------------------------
package shhpc_pkg;

  localparam int unsigned VtxBits = 216;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][15:0] nrm;
    logic [1:0][31:0] tex;
    logic [7:0]       bone;
  } vtx_t;

  localparam logic [1:0] REG_CLIP_AXIS  = 2'd0;
  localparam logic [1:0] REG_CLIP_VALUE = 2'd1;
  localparam logic [1:0] REG_KEEP_HIGH  = 2'd2;

  localparam logic [2:0] FLD_POS_X = 3'd0;
  localparam logic [2:0] FLD_POS_Y = 3'd1;
  localparam logic [2:0] FLD_POS_Z = 3'd2;
  localparam logic [2:0] FLD_NRM_X = 3'd3;
  localparam logic [2:0] FLD_NRM_Y = 3'd4;
  localparam logic [2:0] FLD_NRM_Z = 3'd5;
  localparam logic [2:0] FLD_TEX_U = 3'd6;
  localparam logic [2:0] FLD_TEX_V = 3'd7;

  localparam logic [1:0]  LAST_COMP    = 2'd2;
  localparam logic [1:0]  LAST_SLOT    = 2'd3;
  localparam logic [14:0] NORM_ONE     = 15'd16384;
  localparam logic [3:0]  NORM_TOP_BIT = 4'd14;
  localparam logic [5:0]  DIV_STEPS    = 6'd33;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PLAN,
    ST_SLOT,
    ST_DIVGO,
    ST_DIV,
    ST_MIX_MUL,
    ST_MIX_ACC,
    ST_SQ_MUL,
    ST_SQ_ACC,
    ST_NR_CHK,
    ST_NR_U,
    ST_NR_US,
    ST_NR_CMP,
    ST_EMIT,
    ST_FIN
  } state_e;

  function automatic vtx_t unpack_vtx(logic [VtxBits-1:0] d);
    vtx_t v;
    v.pos[0] = d[31:0];
    v.pos[1] = d[63:32];
    v.pos[2] = d[95:64];
    v.nrm[0] = d[111:96];
    v.nrm[1] = d[127:112];
    v.nrm[2] = d[143:128];
    v.tex[0] = d[175:144];
    v.tex[1] = d[207:176];
    v.bone   = d[215:208];
    return v;
  endfunction

  function automatic logic [VtxBits-1:0] pack_vtx(vtx_t v);
    return {v.bone, v.tex[1], v.tex[0], v.nrm[2], v.nrm[1], v.nrm[0],
            v.pos[2], v.pos[1], v.pos[0]};
  endfunction

  function automatic logic signed [31:0] tcoord(vtx_t v, logic axis);
    return axis ? $signed(v.tex[1]) : $signed(v.tex[0]);
  endfunction

  function automatic logic kept(vtx_t v, logic axis, logic signed [31:0] clip,
                                logic upper);
    logic signed [31:0] c;
    c = tcoord(v, axis);
    return upper ? (c >= clip) : (c <= clip);
  endfunction

  // Field k sign-extended to 33 bits.
  function automatic logic [32:0] fld_get(vtx_t v, logic [2:0] k);
    logic [32:0] r;
    case (k)
      FLD_POS_X: r = {v.pos[0][31], v.pos[0]};
      FLD_POS_Y: r = {v.pos[1][31], v.pos[1]};
      FLD_POS_Z: r = {v.pos[2][31], v.pos[2]};
      FLD_NRM_X: r = {{17{v.nrm[0][15]}}, v.nrm[0]};
      FLD_NRM_Y: r = {{17{v.nrm[1][15]}}, v.nrm[1]};
      FLD_NRM_Z: r = {{17{v.nrm[2][15]}}, v.nrm[2]};
      FLD_TEX_U: r = {v.tex[0][31], v.tex[0]};
      FLD_TEX_V: r = {v.tex[1][31], v.tex[1]};
      default:   r = '0;
    endcase
    return r;
  endfunction

  function automatic vtx_t fld_set(vtx_t v, logic [2:0] k, logic [32:0] val);
    vtx_t r;
    r = v;
    case (k)
      FLD_POS_X: r.pos[0] = val[31:0];
      FLD_POS_Y: r.pos[1] = val[31:0];
      FLD_POS_Z: r.pos[2] = val[31:0];
      FLD_NRM_X: r.nrm[0] = val[15:0];
      FLD_NRM_Y: r.nrm[1] = val[15:0];
      FLD_NRM_Z: r.nrm[2] = val[15:0];
      FLD_TEX_U: r.tex[0] = val[31:0];
      FLD_TEX_V: r.tex[1] = val[31:0];
      default:   r = v;
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/shhpc_div.sv =====
// ----------------------------------------------------------------------------
// Interpolation divider
// Restoring divider, one quotient bit per cycle, for the Q1.32 cut fraction.
// ----------------------------------------------------------------------------
module shhpc_div import shhpc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [32:0] num_i,
  input  logic [32:0] den_i,
  output logic [32:0] quo_o,
  output logic        done_o
);

  logic [32:0] rem_q, dvd_q, den_q, quo_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic [33:0] trial, diff;
  logic        ge;

  // The dividend is num * 2^32 + den / 2; its top 32 bits seed the remainder.
  assign trial = {rem_q, dvd_q[32]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= DIV_STEPS;
    end else if (busy_q && cnt_q != 6'd0) begin
      cnt_q <= cnt_q - 6'd1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i[32:1]};
      dvd_q <= {num_i[0], den_i[32:1]};
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q && cnt_q != 6'd0) begin
      rem_q <= ge ? diff[32:0] : trial[32:0];
      dvd_q <= {dvd_q[31:0], 1'b0};
      quo_q <= {quo_q[31:0], ge};
    end
  end

  assign quo_o  = quo_q;
  assign done_o = busy_q && (cnt_q == 6'd0);

endmodule

// ===== hw/rtl/shhpc_mul.sv =====
// ----------------------------------------------------------------------------
// Shared multiplier
// Unsigned 32 x 32 multiplier with a registered 64-bit product.
// ----------------------------------------------------------------------------
module shhpc_mul import shhpc_pkg::*; (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= {32'd0, a_i} * {32'd0, b_i};
  end

  assign p_o = p_q;

endmodule

// ===== hw/rtl/sutherland_hodgman_half_plane_clip.sv =====
// ----------------------------------------------------------------------------
// Half-plane polygon clipper
// Clips a vertex stream against one texture-space boundary, one vertex a beat.
// ----------------------------------------------------------------------------
// One vertex is taken at a time; the input stalls until its results are out.
// Each passed vertex waits for the output to be free. A cut runs the divider,
// interpolates the eight fields, squares the normal components and, unless the
// normal is zero, renormalizes them by a bitwise search over 15 bits each.
// Reset clears the open polygon and sets the registers to axis u, 0, keep upper.
`include "assert_macros.svh"

module sutherland_hodgman_half_plane_clip import shhpc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v, bone_index
  input  logic [215:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_pos_x/y/z, out_norm_x/y/z, out_tex_u, out_tex_v, out_bone
  output logic [215:0] m_axis_tdata,
  // vertex_valid, run_end
  output logic [1:0]   m_axis_tuser,
  output logic         m_axis_tlast
);

  state_e state_q, state_d;

  logic               axis_q, upper_q;
  logic signed [31:0] clip_q;

  vtx_t cur_q, cur_d, first_q, first_d, prev_q, prev_d;
  vtx_t lo_q, lo_d, hi_q, hi_d, res_q, res_d;
  logic seen_q, seen_d, last_q, last_d, vv_q, vv_d;
  logic [3:0] plan_q, plan_d;
  logic [1:0] slot_q, slot_d, comp_q, comp_d;
  logic [2:0] fld_q, fld_d;
  logic [3:0] bit_q, bit_d;
  logic [14:0] q_q, q_d;
  logic [31:0] s_q, s_d;
  logic [2:0][30:0] sq_q, sq_d;

  vtx_t out_vtx_q, out_vtx_d;
  logic out_valid_q, out_valid_d, out_vv_q, out_vv_d;
  logic out_re_q, out_re_d, out_pe_q, out_pe_d;

  logic        div_start, div_done;
  logic [32:0] div_num, div_den, quo;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  vtx_t ea, eb;
  logic signed [31:0] ca, cb, clo, chi;
  logic k_prev, k_cur, k_first;
  logic [32:0] fa, fb, fd, fmag, r, fres;
  logic [64:0] rnd;
  logic        fneg;
  logic [15:0] ncur, nfin;
  logic [16:0] nsx, nmag;
  logic [14:0] c, qn;
  logic [15:0] u;
  logic [63:0] rhs;
  logic        adv, run_end, out_free;
  logic [3:0]  rest;

  shhpc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .quo_o  (quo),
    .done_o (div_done)
  );

  shhpc_mul u_mul (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (mul_p)
  );

  // Edge endpoints of the current slot: the first edge runs previous to
  // current, the closing edge current to first.
  assign ea = slot_q[1] ? cur_q : prev_q;
  assign eb = slot_q[1] ? first_q : cur_q;
  assign ca = tcoord(ea, axis_q);
  assign cb = tcoord(eb, axis_q);

  assign k_prev  = kept(prev_q, axis_q, clip_q, upper_q);
  assign k_cur   = kept(cur_q, axis_q, clip_q, upper_q);
  assign k_first = kept(first_q, axis_q, clip_q, upper_q);

  assign clo     = tcoord(lo_q, axis_q);
  assign chi     = tcoord(hi_q, axis_q);
  assign div_num = {clip_q[31], clip_q} - {clo[31], clo};
  assign div_den = {chi[31], chi} - {clo[31], clo};

  // Interpolation of one field from the lower endpoint toward the upper one.
  assign fa   = fld_get(lo_q, fld_q);
  assign fb   = fld_get(hi_q, fld_q);
  assign fd   = fb - fa;
  assign fneg = fd[32];
  assign fmag = fneg ? (33'd0 - fd) : fd;
  assign rnd  = {1'b0, mul_p} + 65'd2147483648;
  assign r    = quo[32] ? fmag : rnd[64:32];
  assign fres = fneg ? (fa - r) : (fa + r);

  // Normal renormalization: bitwise search for the largest q with
  // (2q-1)^2 * s <= n^2 * 2^30.
  assign ncur = res_q.nrm[comp_q];
  assign nsx  = {ncur[15], ncur};
  assign nmag = ncur[15] ? (17'd0 - nsx) : nsx;
  assign c    = q_q | (15'd1 << bit_q);
  assign u    = {c, 1'b0} - 16'd1;
  assign rhs  = {3'b000, sq_q[comp_q], 30'd0};
  assign qn   = (state_q == ST_NR_CMP && mul_p <= rhs) ? c : q_q;
  assign nfin = ncur[15] ? (16'd0 - {1'b0, qn}) : {1'b0, qn};

  assign rest     = (plan_q >> slot_q) >> 1;
  assign run_end  = (rest == 4'd0);
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d     = state_q;
    cur_d       = cur_q;
    first_d     = first_q;
    prev_d      = prev_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    res_d       = res_q;
    seen_d      = seen_q;
    last_d      = last_q;
    vv_d        = vv_q;
    plan_d      = plan_q;
    slot_d      = slot_q;
    comp_d      = comp_q;
    fld_d       = fld_q;
    bit_d       = bit_q;
    q_d         = q_q;
    s_d         = s_q;
    sq_d        = sq_q;
    out_vtx_d   = out_vtx_q;
    out_vv_d    = out_vv_q;
    out_re_d    = out_re_q;
    out_pe_d    = out_pe_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    div_start   = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    adv         = 1'b0;
    s_axis_tready = 1'b0;

    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cur_d  = unpack_vtx(s_axis_tdata);
          last_d = s_axis_tlast;
          if (!seen_q) begin
            first_d = unpack_vtx(s_axis_tdata);
          end
          state_d = ST_PLAN;
        end
      end
      ST_PLAN: begin
        plan_d = {last_q & (k_cur ^ k_first), last_q & k_cur,
                  seen_q & (k_prev ^ k_cur), seen_q & k_prev};
        slot_d = 2'd0;
        state_d = ST_SLOT;
        if (last_q && plan_d == 4'd0) begin
          // Nothing survives: close the polygon with an empty marker.
          res_d   = '0;
          vv_d    = 1'b0;
          slot_d  = LAST_SLOT;
          state_d = ST_EMIT;
        end
      end
      ST_SLOT: begin
        if (plan_q[slot_q]) begin
          vv_d = 1'b1;
          if (!slot_q[0]) begin
            res_d   = ea;
            state_d = ST_EMIT;
          end else begin
            lo_d    = (ca < cb) ? ea : eb;
            hi_d    = (ca < cb) ? eb : ea;
            state_d = ST_DIVGO;
          end
        end else if (slot_q == LAST_SLOT) begin
          state_d = ST_FIN;
        end else begin
          slot_d = slot_q + 2'd1;
        end
      end
      ST_DIVGO: begin
        div_start  = 1'b1;
        res_d.bone = lo_q.bone;
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          fld_d   = FLD_POS_X;
          state_d = ST_MIX_MUL;
        end
      end
      ST_MIX_MUL: begin
        mul_a   = fmag[31:0];
        mul_b   = quo[31:0];
        state_d = ST_MIX_ACC;
      end
      ST_MIX_ACC: begin
        res_d = fld_set(res_q, fld_q, fres);
        if (fld_q == FLD_TEX_V) begin
          comp_d  = 2'd0;
          s_d     = '0;
          state_d = ST_SQ_MUL;
        end else begin
          fld_d   = fld_q + 3'd1;
          state_d = ST_MIX_MUL;
        end
      end
      ST_SQ_MUL: begin
        mul_a   = {15'd0, nmag};
        mul_b   = {15'd0, nmag};
        state_d = ST_SQ_ACC;
      end
      ST_SQ_ACC: begin
        sq_d[comp_q] = mul_p[30:0];
        s_d          = s_q + mul_p[31:0];
        if (comp_q == LAST_COMP) begin
          state_d = ST_NR_CHK;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = ST_SQ_MUL;
        end
      end
      ST_NR_CHK: begin
        if (s_q == 32'd0) begin
          state_d = ST_EMIT;
        end else begin
          comp_d  = 2'd0;
          bit_d   = NORM_TOP_BIT;
          q_d     = '0;
          state_d = ST_NR_U;
        end
      end
      ST_NR_U: begin
        if (c > NORM_ONE) begin
          adv = 1'b1;
        end else begin
          mul_a   = {16'd0, u};
          mul_b   = {16'd0, u};
          state_d = ST_NR_US;
        end
      end
      ST_NR_US: begin
        mul_a   = mul_p[31:0];
        mul_b   = s_q;
        state_d = ST_NR_CMP;
      end
      ST_NR_CMP: begin
        adv = 1'b1;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_vtx_d   = res_q;
          out_vv_d    = vv_q;
          out_re_d    = run_end;
          out_pe_d    = run_end && last_q;
          out_valid_d = 1'b1;
          if (slot_q == LAST_SLOT) begin
            state_d = ST_FIN;
          end else begin
            slot_d  = slot_q + 2'd1;
            state_d = ST_SLOT;
          end
        end
      end
      ST_FIN: begin
        if (last_q) begin
          seen_d = 1'b0;
        end else begin
          prev_d = cur_q;
          seen_d = 1'b1;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (adv) begin
      if (bit_q == 4'd0) begin
        res_d.nrm[comp_q] = nfin;
        q_d   = '0;
        bit_d = NORM_TOP_BIT;
        if (comp_q == LAST_COMP) begin
          state_d = ST_EMIT;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = ST_NR_U;
        end
      end else begin
        q_d     = qn;
        bit_d   = bit_q - 4'd1;
        state_d = ST_NR_U;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q  <= 1'b0;
      clip_q  <= '0;
      upper_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CLIP_AXIS:  axis_q  <= cfg_data_i[0];
        REG_CLIP_VALUE: clip_q  <= cfg_data_i;
        REG_KEEP_HIGH:  upper_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
      plan_q      <= '0;
      slot_q      <= '0;
      comp_q      <= '0;
      fld_q       <= '0;
      bit_q       <= '0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
      plan_q      <= plan_d;
      slot_q      <= slot_d;
      comp_q      <= comp_d;
      fld_q       <= fld_d;
      bit_q       <= bit_d;
      last_q      <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    first_q   <= first_d;
    prev_q    <= prev_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    res_q     <= res_d;
    vv_q      <= vv_d;
    q_q       <= q_d;
    s_q       <= s_d;
    sq_q      <= sq_d;
    out_vtx_q <= out_vtx_d;
    out_vv_q  <= out_vv_d;
    out_re_q  <= out_re_d;
    out_pe_q  <= out_pe_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = pack_vtx(out_vtx_q);
  assign m_axis_tuser  = {out_re_q, out_vv_q};
  assign m_axis_tlast  = out_pe_q;

  `SHHPC_ASSERT_IMPL(a_marker_closes, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast && m_axis_tuser[1])
  `SHHPC_ASSERT_IMPL(a_last_ends_run, clk_i, rst_ni, m_axis_tvalid && m_axis_tlast, m_axis_tuser[1])
  `SHHPC_ASSERT_NEXT(a_one_vertex, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)

endmodule
